// ===== rtl/bpa_pkg.sv =====
// Package for the bit packet assembler: command codes, payload structs,
// queue entry type and the CRC byte step. No dependencies.
`default_nettype none
package bpa_pkg;
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_PAD    = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_CRC    = 3'd4;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [5:0]  bit_count;
    logic        msb_first;
    logic [9:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [15:0] crc_out;
    logic [10:0] fill_bits;
    logic        status;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_APPEND,
    OP_PAD,
    OP_READ,
    OP_CRC
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
    logic [5:0]  bit_count;
    logic        msb_first;
    logic [9:0]  position;
  } task_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_CRC,
    ST_OUT
  } state_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] byte_in);
    logic [15:0] c;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      c = c ^ {byte_in[i], 15'd0};
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/bpa_front.sv =====
// Front end: accepts command items, classifies them and pushes tasks into
// a two-entry queue. Depends on bpa_pkg.
`default_nettype none
module bpa_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire bpa_pkg::in_item_t in_data,
  output logic                  q_valid,
  output bpa_pkg::task_t        q_task,
  input  wire logic             q_pop
);
  bpa_pkg::task_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic       push;
  bpa_pkg::task_t t;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_task   = q_r[rd_r];

  always_comb begin
    t.value     = in_data.value;
    t.bit_count = in_data.bit_count;
    t.msb_first = in_data.msb_first;
    t.position  = in_data.position;
    unique case (in_data.cmd)
      bpa_pkg::CMD_CLEAR:  t.op = bpa_pkg::OP_CLEAR;
      bpa_pkg::CMD_APPEND: t.op = bpa_pkg::OP_APPEND;
      bpa_pkg::CMD_PAD:    t.op = bpa_pkg::OP_PAD;
      bpa_pkg::CMD_READ:   t.op = bpa_pkg::OP_READ;
      bpa_pkg::CMD_CRC:    t.op = bpa_pkg::OP_CRC;
      default:             t.op = bpa_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) q_r[wr_r] <= t;
  end
endmodule
`default_nettype wire

// ===== rtl/bpa_back.sv =====
// Back end: executes tasks on the packet store (a 64-bit word memory),
// walks bytes for CRC and holds the result register. Depends on bpa_pkg.
`default_nettype none
module bpa_back #(
  parameter int PACKET_BITS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire bpa_pkg::task_t   q_task,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output bpa_pkg::out_item_t    out_data
);
  localparam int WORDS = (PACKET_BITS + 63) / 64;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = $clog2(PACKET_BITS + 1);
  localparam int BW    = $clog2(PACKET_BITS / 8 + 1);

  logic [63:0]  mem [WORDS];
  logic [WORDS-1:0] vld_r;

  bpa_pkg::state_t st_r, st_nxt;
  bpa_pkg::task_t  tk_r;
  logic [PW-1:0]   ptr_r;
  logic [WAW-1:0]  wa_r;
  logic            half_r;
  logic [63:0]     w0_r, w1_r;
  logic [63:0]     rd_q;
  logic [BW-1:0]   bi_r, bend_r;
  logic [15:0]     crc_r;
  bpa_pkg::out_item_t res_r;
  logic            ov_r;
  logic            vq_r;
  logic [63:0]     rdv;
  logic            rpend_r;
  logic            ph_r;

  logic [PW:0]     app_end, pad_end, rd_end;
  logic [6:0]      padn;
  logic            len_ok;
  logic [5:0]      boff;
  logic [127:0]    win, mask, fld, nwin;
  logic [31:0]     vsel, rsel, rraw;
  logic [WAW-1:0]  raddr;
  logic            rd_en;
  logic [7:0]      cbyte;
  logic [BW-1:0]   pe;
  bpa_pkg::out_item_t res_nxt;
  logic [PW-1:0]   ptr_nxt;

  assign out_valid = ov_r;
  assign out_data  = res_r;

  always_comb begin
    len_ok  = (tk_r.bit_count >= 6'd1) && (tk_r.bit_count <= 6'd32);
    app_end = {1'b0, ptr_r} + (PW+1)'(tk_r.bit_count);
    padn    = 7'd8 - 7'(ptr_r[2:0]);
    pad_end = {1'b0, ptr_r} + (PW+1)'(padn);
    rd_end  = (PW+1)'(tk_r.position) + (PW+1)'(tk_r.bit_count);
    pe      = BW'((PW+1)'(ptr_r) + (PW+1)'(1) >> 3);
  end

  // window of two 64-bit words around the field; the upper word comes
  // straight from the read port in the cycle it arrives
  always_comb begin
    logic [PW-1:0] base;
    base = (tk_r.op == bpa_pkg::OP_READ) ? PW'(tk_r.position) : ptr_r;
    boff = base[5:0];
    win  = {(rpend_r && !half_r) ? rdv : w1_r, w0_r};
    for (int i = 0; i < 32; i++) begin
      vsel[i] = tk_r.msb_first ? ((6'(i) < tk_r.bit_count) ?
                tk_r.value[5'(tk_r.bit_count - 6'd1 - 6'(i))] : 1'b0) :
                tk_r.value[i];
    end
    if (tk_r.op == bpa_pkg::OP_PAD) begin
      mask = 128'((64'd1 << padn) - 64'd1) << boff;
      fld  = 128'd0;
    end else begin
      mask = 128'((64'd1 << tk_r.bit_count) - 64'd1) << boff;
      fld  = (128'(vsel) << boff) & mask;
    end
    nwin = (win & ~mask) | fld;
    rraw = 32'(win >> boff) & 32'((64'd1 << tk_r.bit_count) - 64'd1);
    for (int i = 0; i < 32; i++) begin
      rsel[i] = tk_r.msb_first ? ((6'(i) < tk_r.bit_count) ?
                rraw[5'(tk_r.bit_count - 6'd1 - 6'(i))] : 1'b0) : rraw[i];
    end
  end

  always_comb begin
    cbyte = rdv[8*bi_r[2:0] +: 8];
  end

  always_comb begin
    res_nxt = '0;
    ptr_nxt = ptr_r;
    unique case (tk_r.op)
      bpa_pkg::OP_CLEAR: ptr_nxt = '0;
      bpa_pkg::OP_APPEND:
        if (len_ok && app_end <= (PW+1)'(PACKET_BITS)) ptr_nxt = PW'(app_end);
        else res_nxt.status = 1'b1;
      bpa_pkg::OP_PAD:
        if (pad_end <= (PW+1)'(PACKET_BITS)) ptr_nxt = PW'(pad_end);
        else res_nxt.status = 1'b1;
      bpa_pkg::OP_READ:
        if (len_ok && rd_end <= (PW+1)'(PACKET_BITS)) res_nxt.data_out = rsel;
        else res_nxt.status = 1'b1;
      bpa_pkg::OP_CRC: res_nxt.crc_out = ~crc_r;
      default: res_nxt.status = 1'b1;
    endcase
    res_nxt.fill_bits = 11'(ptr_nxt);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bpa_pkg::ST_IDLE: if (q_valid && !ov_r) st_nxt = bpa_pkg::ST_RD;
      bpa_pkg::ST_RD:   if (half_r) begin
        priority if ((tk_r.op == bpa_pkg::OP_APPEND && len_ok &&
                      app_end <= (PW+1)'(PACKET_BITS)) ||
                     (tk_r.op == bpa_pkg::OP_PAD &&
                      pad_end <= (PW+1)'(PACKET_BITS)))
          st_nxt = bpa_pkg::ST_WR;
        else if (tk_r.op == bpa_pkg::OP_CRC && 16'(tk_r.position) < 16'(bend_r))
          st_nxt = bpa_pkg::ST_CRC;
        else
          st_nxt = bpa_pkg::ST_OUT;
      end
      bpa_pkg::ST_WR:   if (half_r) st_nxt = bpa_pkg::ST_OUT;
      bpa_pkg::ST_CRC:  if (ph_r && bi_r + BW'(1) == bend_r) st_nxt = bpa_pkg::ST_OUT;
      bpa_pkg::ST_OUT:  st_nxt = bpa_pkg::ST_IDLE;
      default:          st_nxt = bpa_pkg::ST_IDLE;
    endcase
  end

  // pop and read-port control; in the crc byte walk a byte is fetched while ph_r is low and folded while it is high
  always_comb begin
    q_pop = (st_r == bpa_pkg::ST_IDLE) && q_valid && !ov_r;
    rd_en = 1'b0;
    raddr = wa_r;
    unique case (st_r)
      bpa_pkg::ST_RD:  begin rd_en = 1'b1; raddr = wa_r + WAW'(half_r); end
      bpa_pkg::ST_CRC: begin rd_en = !ph_r; raddr = WAW'(bi_r >> 3); end
      default: ;
    endcase
  end

  // read, with a registered data path; unwritten words read zero
  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= mem[raddr];
    vq_r <= vld_r[raddr];
  end
  assign rdv = vq_r ? rd_q : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= bpa_pkg::ST_IDLE;
      ptr_r   <= '0;
      ov_r    <= 1'b0;
      vld_r   <= '0;
      half_r  <= 1'b0;
      rpend_r <= 1'b0;
      ph_r    <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      rpend_r <= (st_r == bpa_pkg::ST_RD);
      if (rpend_r) begin
        if (!half_r) w1_r <= rdv; else w0_r <= rdv;
      end
      unique case (st_r)
        bpa_pkg::ST_IDLE: begin
          half_r <= 1'b0;
          ph_r   <= 1'b0;
          if (q_pop) begin
            tk_r <= q_task;
            wa_r <= (q_task.op == bpa_pkg::OP_READ) ?
                    WAW'(q_task.position >> 6) : WAW'(ptr_r >> 6);
            bend_r <= (pe > BW'(PACKET_BITS / 8)) ? BW'(PACKET_BITS / 8) : pe;
            bi_r   <= BW'(q_task.position);
            crc_r  <= bpa_pkg::CRC_SEED;
          end
        end
        bpa_pkg::ST_RD: half_r <= ~half_r;
        bpa_pkg::ST_WR: begin
          half_r <= ~half_r;
          if (!half_r) begin
            mem[wa_r] <= nwin[63:0];
            vld_r[wa_r] <= 1'b1;
          end else if (wa_r != WAW'(WORDS - 1)) begin
            mem[wa_r + WAW'(1)] <= nwin[127:64];
            vld_r[wa_r + WAW'(1)] <= 1'b1;
          end
        end
        bpa_pkg::ST_CRC: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            bi_r  <= bi_r + BW'(1);
            crc_r <= bpa_pkg::crc_byte(crc_r, cbyte);
          end
        end
        bpa_pkg::ST_OUT: begin
          ov_r  <= 1'b1;
          res_r <= res_nxt;
          ptr_r <= ptr_nxt;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bit_packet_assembler_crc.sv =====
// Top level of the bit packet assembler with CRC-16.
// Throughput: the back end runs one item at a time and takes the next the cycle
// after its result is accepted; a two-entry queue decouples the input.
// Reset: synchronous active-low clears pointer, queue and store valid bits.
`default_nettype none
module bit_packet_assembler_crc #(
  parameter int PACKET_BITS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bpa_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bpa_pkg::out_item_t      out_data
);
  logic           q_valid, q_pop;
  bpa_pkg::task_t q_task;

  bpa_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_task(q_task), .q_pop(q_pop)
  );

  bpa_back #(.PACKET_BITS(PACKET_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_task(q_task),
    .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );
endmodule
`default_nettype wire
